// ===== rtl/core/dwgs_pkg.sv =====
// Package for the dual window gradient sensor.
// Field widths, register indexes, step counts and the sequencer state type.
// No dependencies.
package dwgs_pkg;

    localparam int DIST_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int LEN_W    = 7;
    localparam int LEVEL_W  = 20;
    localparam int CONC_W   = 21;
    localparam int SUM_W    = 28;
    localparam int PROD_W   = DIST_W + GAIN_W;
    localparam int MAG_W    = PROD_W - 12;
    localparam int K_W      = 8;
    localparam int FILL_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int HISTORY_DEPTH_DEF = 256;

    localparam int MUL_STEPS   = DIST_W;
    localparam int PRIME_STEPS = LEN_W;
    localparam int MOD_STEPS   = K_W;
    localparam int DIV_STEPS   = SUM_W;
    localparam int CNT_W       = 5;

    localparam logic [GAIN_W-1:0] GAIN_RST = 16'd4096;
    localparam logic [LEN_W-1:0]  LEN_RST  = 7'd8;
    localparam logic [FILL_W-1:0] FILL_MAX = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 20'hFFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN    = 2'd0,
        CFG_PRESENT = 2'd1,
        CFG_PAST    = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_PRIME,
        ST_PSET,
        ST_WRITE,
        ST_MOD,
        ST_RDA,
        ST_RDB,
        ST_SUM,
        ST_DSET,
        ST_DIV,
        ST_SIGN,
        ST_DIFF,
        ST_OUT
    } dwgs_state_t;

endpackage

// ===== rtl/core/dwgs_in_if.sv =====
// Input sample channel: valid/ready with distance and restart flag.
// Depends on dwgs_pkg.
interface dwgs_in_if
    import dwgs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic              restart;

    modport source (output valid, output distance, output restart, input ready);
    modport sink   (input valid, input distance, input restart, output ready);
endinterface

// ===== rtl/core/dwgs_out_if.sv =====
// Result channel: valid/ready with ON and OFF levels.
// Depends on dwgs_pkg.
interface dwgs_out_if
    import dwgs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] on_level;
    logic [LEVEL_W-1:0] off_level;

    modport source (output valid, output on_level, output off_level, input ready);
    modport sink   (input valid, input on_level, input off_level, output ready);
endinterface

// ===== rtl/core/dwgs_cfg_if.sv =====
// Configuration write channel: valid/ready with register index and data.
// Depends on dwgs_pkg.
interface dwgs_cfg_if
    import dwgs_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/dual_window_gradient_sensor.sv =====
// Dual window gradient sensor: present mean minus past mean of a concentration ring.
// Depends on dwgs_pkg, dwgs_in_if, dwgs_out_if, dwgs_cfg_if.
//
//  channel  | dir | payload                      | transaction
//  ---------+-----+------------------------------+------------------------
//  sample   | in  | distance[15:0], restart      | valid & ready
//  result   | out | on_level[19:0], off_level    | valid & ready
//  cfg      | in  | index[1:0], data[15:0]       | valid & ready (always ready)
//
// One sample transaction at a time. A normal sample runs a 16-step bit-serial multiply,
// an 8-step offset reduction, a history write and two history reads, then two 28-step
// restoring dividers running side by side. A restart runs the multiply and then primes
// the window sums instead.
// The result register frees the sequencer unless a previous result is still unread.
// rst_n is asynchronous; the history RAM is not cleared, no clearing pass.
module dual_window_gradient_sensor
    import dwgs_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    dwgs_in_if.sink    sample,
    dwgs_out_if.source result,
    dwgs_cfg_if.sink   cfg
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [AW:0]   DEPTH_W = (AW+1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] WP_LAST = AW'(HISTORY_DEPTH - 1);

    dwgs_state_t state_reg, state_next;

    logic [GAIN_W-1:0] gain_reg;
    logic [LEN_W-1:0]  present_len_reg;
    logic [LEN_W-1:0]  past_len_reg;

    logic [AW-1:0]           wp_reg;
    logic [FILL_W-1:0]       fill_reg;
    logic signed [CONC_W-1:0] prime_reg;
    logic signed [SUM_W-1:0] present_sum_reg;
    logic signed [SUM_W-1:0] past_sum_reg;

    logic [CNT_W-1:0]  cnt_reg;
    logic              restart_reg;
    logic [LEN_W-1:0]  n_reg;
    logic [LEN_W-1:0]  m_reg;
    logic [PROD_W-1:0] prod_reg;
    logic signed [CONC_W-1:0] c_reg;

    logic [SUM_W-2:0]  pacc_n_reg;
    logic [SUM_W-2:0]  pacc_m_reg;
    logic [SUM_W-2:0]  pmag_reg;
    logic [LEN_W-1:0]  psh_n_reg;
    logic [LEN_W-1:0]  psh_m_reg;

    logic [K_W-1:0]    ka_sh_reg;
    logic [K_W-1:0]    kb_sh_reg;
    logic [AW-1:0]     ra_mod_reg;
    logic [AW-1:0]     rb_mod_reg;
    logic              pa_reg;
    logic              pb_reg;

    logic signed [CONC_W-1:0] mem [HISTORY_DEPTH];
    logic signed [CONC_W-1:0] rd_data_reg;
    logic signed [CONC_W-1:0] a_reg;

    logic [SUM_W-1:0]  da_reg;
    logic [SUM_W-1:0]  db_reg;
    logic [LEN_W-1:0]  ra_reg;
    logic [LEN_W-1:0]  rb_reg;
    logic              sa_reg;
    logic              sb_reg;
    logic signed [SUM_W:0]   qa_reg;
    logic signed [SUM_W:0]   qb_reg;
    logic signed [SUM_W+1:0] diff_reg;

    logic               out_valid_reg;
    logic [LEVEL_W-1:0] on_reg;
    logic [LEVEL_W-1:0] off_reg;

    // sequencer outputs
    logic          in_ready;
    logic          mem_we;
    logic          out_load;
    logic [AW-1:0] rd_addr;

    // combinational datapath
    logic [GAIN_W:0]    mul_sum;
    logic [AW:0]        mod_a_t;
    logic [AW:0]        mod_b_t;
    logic [AW:0]        idx_a_t;
    logic [AW:0]        idx_b_t;
    logic [AW-1:0]      idx_a;
    logic [AW-1:0]      idx_b;
    logic [LEN_W:0]     div_a_t;
    logic [LEN_W:0]     div_b_t;
    logic               div_a_ge;
    logic               div_b_ge;
    logic signed [CONC_W-1:0] b_val;
    logic [FILL_W-1:0]  fill_inc;
    logic signed [SUM_W+1:0] diff_neg;
    logic [LEVEL_W-1:0] on_next;
    logic [LEVEL_W-1:0] off_next;

    assign sample.ready    = in_ready;
    assign cfg.ready       = 1'b1;
    assign result.valid    = out_valid_reg;
    assign result.on_level = on_reg;
    assign result.off_level = off_reg;

    // datapath helpers
    assign mul_sum  = {1'b0, prod_reg[PROD_W-1:DIST_W]} + (prod_reg[0] ? {1'b0, gain_reg} : '0);

    assign mod_a_t  = {ra_mod_reg, ka_sh_reg[K_W-1]};
    assign mod_b_t  = {rb_mod_reg, kb_sh_reg[K_W-1]};

    assign idx_a_t  = {1'b0, wp_reg} - {1'b0, ra_mod_reg};
    assign idx_b_t  = {1'b0, wp_reg} - {1'b0, rb_mod_reg};
    assign idx_a    = idx_a_t[AW] ? AW'(idx_a_t + DEPTH_W) : idx_a_t[AW-1:0];
    assign idx_b    = idx_b_t[AW] ? AW'(idx_b_t + DEPTH_W) : idx_b_t[AW-1:0];

    assign div_a_t  = {ra_reg, da_reg[SUM_W-1]};
    assign div_b_t  = {rb_reg, db_reg[SUM_W-1]};
    assign div_a_ge = div_a_t >= {1'b0, n_reg};
    assign div_b_ge = div_b_t >= {1'b0, m_reg};

    assign b_val    = pb_reg ? prime_reg : rd_data_reg;
    assign fill_inc = (fill_reg == FILL_MAX) ? FILL_MAX : fill_reg + 1'b1;
    assign diff_neg = -diff_reg;

    always_comb
    begin
        on_next  = '0;
        off_next = '0;
        if (diff_reg > 0)
        begin
            on_next = (diff_reg > (SUM_W+2)'(LEVEL_MAX)) ? LEVEL_MAX : diff_reg[LEVEL_W-1:0];
        end
        else if (diff_reg < 0)
        begin
            off_next = (diff_neg > (SUM_W+2)'(LEVEL_MAX)) ? LEVEL_MAX : diff_neg[LEVEL_W-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (sample.valid) state_next = ST_MUL;
            ST_MUL:   if (cnt_reg == CNT_W'(MUL_STEPS-1))
                          state_next = restart_reg ? ST_PRIME : ST_WRITE;
            ST_PRIME: if (cnt_reg == CNT_W'(PRIME_STEPS-1)) state_next = ST_PSET;
            ST_PSET:  state_next = ST_OUT;
            ST_WRITE: state_next = ST_MOD;
            ST_MOD:   if (cnt_reg == CNT_W'(MOD_STEPS-1)) state_next = ST_RDA;
            ST_RDA:   state_next = ST_RDB;
            ST_RDB:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_DSET;
            ST_DSET:  state_next = ST_DIV;
            ST_DIV:   if (cnt_reg == CNT_W'(DIV_STEPS-1)) state_next = ST_SIGN;
            ST_SIGN:  state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_OUT;
            ST_OUT:   if (!out_valid_reg || result.ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        mem_we   = 1'b0;
        out_load = 1'b0;
        rd_addr  = idx_a;
        case (state_reg)
            ST_IDLE:  in_ready = 1'b1;
            ST_WRITE: mem_we = 1'b1;
            ST_RDA:   rd_addr = idx_a;
            ST_RDB:   rd_addr = idx_b;
            ST_OUT:   out_load = !out_valid_reg || result.ready;
            default:  rd_addr = idx_a;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
            begin
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg        <= GAIN_RST;
            present_len_reg <= LEN_RST;
            past_len_reg    <= LEN_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_GAIN:    gain_reg        <= cfg.data[GAIN_W-1:0];
                CFG_PRESENT: present_len_reg <= cfg.data[LEN_W-1:0];
                CFG_PAST:    past_len_reg    <= cfg.data[LEN_W-1:0];
                default:     gain_reg        <= gain_reg;
            endcase
        end
    end

    // history state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg          <= '0;
            fill_reg        <= '0;
            prime_reg       <= '0;
            present_sum_reg <= '0;
            past_sum_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                ST_PSET:
                begin
                    prime_reg       <= c_reg;
                    fill_reg        <= '0;
                    present_sum_reg <= -$signed({1'b0, pacc_n_reg});
                    past_sum_reg    <= -$signed({1'b0, pacc_m_reg});
                end
                ST_WRITE: fill_reg <= fill_inc;
                ST_SUM:
                begin
                    present_sum_reg <= present_sum_reg + SUM_W'(c_reg - a_reg);
                    past_sum_reg    <= past_sum_reg + SUM_W'(a_reg - b_val);
                    wp_reg          <= (wp_reg == WP_LAST) ? '0 : wp_reg + 1'b1;
                end
                default: wp_reg <= wp_reg;
            endcase
        end
    end

    // history RAM
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= c_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // serial datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                prod_reg    <= {{GAIN_W{1'b0}}, sample.distance};
                restart_reg <= sample.restart;
                n_reg       <= (present_len_reg == '0) ? LEN_W'(1) : present_len_reg;
                m_reg       <= (past_len_reg == '0) ? LEN_W'(1) : past_len_reg;
            end
            ST_MUL:
            begin
                prod_reg <= {mul_sum, prod_reg[DIST_W-1:1]};
                if (cnt_reg == CNT_W'(MUL_STEPS-1))
                begin
                    pacc_n_reg <= '0;
                    pacc_m_reg <= '0;
                    pmag_reg   <= {(SUM_W-1-MAG_W)'(0), mul_sum, prod_reg[DIST_W-1:13]};
                    psh_n_reg  <= n_reg;
                    psh_m_reg  <= m_reg;
                    c_reg      <= -$signed({1'b0, mul_sum, prod_reg[DIST_W-1:13]});
                end
            end
            ST_PRIME:
            begin
                if (psh_n_reg[0]) pacc_n_reg <= pacc_n_reg + pmag_reg;
                if (psh_m_reg[0]) pacc_m_reg <= pacc_m_reg + pmag_reg;
                pmag_reg  <= {pmag_reg[SUM_W-3:0], 1'b0};
                psh_n_reg <= {1'b0, psh_n_reg[LEN_W-1:1]};
                psh_m_reg <= {1'b0, psh_m_reg[LEN_W-1:1]};
            end
            ST_PSET:  diff_reg <= '0;
            ST_WRITE:
            begin
                ka_sh_reg  <= {1'b0, n_reg};
                kb_sh_reg  <= {1'b0, n_reg} + {1'b0, m_reg};
                ra_mod_reg <= '0;
                rb_mod_reg <= '0;
                pa_reg     <= {1'b0, n_reg} >= fill_inc;
                pb_reg     <= ({1'b0, n_reg} + {1'b0, m_reg}) >= fill_inc;
            end
            ST_MOD:
            begin
                ra_mod_reg <= (mod_a_t >= DEPTH_W) ? AW'(mod_a_t - DEPTH_W) : AW'(mod_a_t);
                rb_mod_reg <= (mod_b_t >= DEPTH_W) ? AW'(mod_b_t - DEPTH_W) : AW'(mod_b_t);
                ka_sh_reg  <= {ka_sh_reg[K_W-2:0], 1'b0};
                kb_sh_reg  <= {kb_sh_reg[K_W-2:0], 1'b0};
            end
            ST_RDB:   a_reg <= pa_reg ? prime_reg : rd_data_reg;
            ST_DSET:
            begin
                sa_reg <= present_sum_reg[SUM_W-1];
                sb_reg <= past_sum_reg[SUM_W-1];
                da_reg <= present_sum_reg[SUM_W-1] ? SUM_W'(-present_sum_reg)
                                                   : SUM_W'(present_sum_reg);
                db_reg <= past_sum_reg[SUM_W-1] ? SUM_W'(-past_sum_reg)
                                                : SUM_W'(past_sum_reg);
                ra_reg <= '0;
                rb_reg <= '0;
            end
            ST_DIV:
            begin
                ra_reg <= div_a_ge ? LEN_W'(div_a_t - {1'b0, n_reg}) : div_a_t[LEN_W-1:0];
                rb_reg <= div_b_ge ? LEN_W'(div_b_t - {1'b0, m_reg}) : div_b_t[LEN_W-1:0];
                da_reg <= {da_reg[SUM_W-2:0], div_a_ge};
                db_reg <= {db_reg[SUM_W-2:0], div_b_ge};
            end
            ST_SIGN:
            begin
                qa_reg <= sa_reg ? -$signed({1'b0, da_reg}) : $signed({1'b0, da_reg});
                qb_reg <= sb_reg ? -$signed({1'b0, db_reg}) : $signed({1'b0, db_reg});
            end
            ST_DIFF:  diff_reg <= (SUM_W+2)'(qa_reg) - (SUM_W+2)'(qb_reg);
            default:  a_reg <= a_reg;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            on_reg  <= on_next;
            off_reg <= off_next;
        end
    end

    // checks
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || result.ready))
        else $error("result register overwritten");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> !sample.ready)
        else $error("second sample taken while busy");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (ra_reg < n_reg && rb_reg < m_reg))
        else $error("divider remainder out of range");

    a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RDA) |-> ({1'b0, ra_mod_reg} < DEPTH_W && {1'b0, rb_mod_reg} < DEPTH_W))
        else $error("ring offset out of range");

endmodule
